### src/hpq_pkg.sv
// Shared types, constants and the ordering compare of the binary heap priority queue.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package hpq_pkg;

  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CHILD_W = ADDR_W + 2;
  localparam int DATA_W = 32;
  localparam int FILL_W = 6;
  localparam int STAT_W = 2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic set_full;
    logic set_empty;
    logic ins_start;
    logic rm_start;
    logic rm_load;
    logic rd_parent;
    logic rd_children;
    logic up_move;
    logic dn_move;
    logic write_cur;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic pos_zero;
    logic dn_leaf;
    logic up_move_ok;
    logic dn_move_ok;
  } sts_t;

  // True when a must sit above b under the current ordering; strict.
  function automatic logic beats(input data_t a, input data_t b, input logic min_order);
    logic res;
    if (min_order) begin
      res = (a < b);
    end else begin
      res = (a > b);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### src/hpq_ifs.sv
// Channel interfaces of the binary heap priority queue: input, result and configuration.
// Depends on hpq_pkg for the payload types and widths.
`default_nettype none

interface hpq_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  hpq_pkg::data_t       value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface hpq_out_if;
  logic                         valid;
  logic                         ready;
  hpq_pkg::data_t               root_value;
  logic [hpq_pkg::STAT_W-1:0]   status;
  logic [hpq_pkg::FILL_W-1:0]   fill_count;

  modport source (output valid, output root_value, output status, output fill_count,
                  input ready);
  modport sink   (input valid, input root_value, input status, input fill_count,
                  output ready);
endinterface

interface hpq_cfg_if;
  logic valid;
  logic ready;
  logic min_order;

  modport source (output valid, output min_order, input ready);
  modport sink   (input valid, input min_order, output ready);
endinterface

`default_nettype wire

### src/hpq_ctrl.sv
// Controller state machine of the binary heap priority queue.
// Depends on hpq_pkg for the command and status structs.
`default_nettype none

module hpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire hpq_pkg::sts_t sts,
  output hpq_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_RM_LOAD = 3'd2;
  localparam logic [2:0] S_UP_RD   = 3'd3;
  localparam logic [2:0] S_UP_CMP  = 3'd4;
  localparam logic [2:0] S_DN_RD   = 3'd5;
  localparam logic [2:0] S_DN_CMP  = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.is_remove) begin
          if (sts.full) begin
            cmd.set_full = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            cmd.ins_start = 1'b1;
            state_nxt     = S_UP_RD;
          end
        end else if (sts.empty) begin
          cmd.set_empty = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.rm_start = 1'b1;
          state_nxt    = S_RM_LOAD;
        end
      end
      S_RM_LOAD: begin
        cmd.rm_load = 1'b1;
        state_nxt   = sts.empty ? S_DONE : S_DN_RD;
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.write_cur = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_move_ok) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.write_cur = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DN_RD: begin
        if (sts.dn_leaf) begin
          cmd.write_cur = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.rd_children = 1'b1;
          state_nxt       = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.dn_move_ok) begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_RD;
        end else begin
          cmd.write_cur = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### src/hpq_dp.sv
// Datapath of the binary heap priority queue: element memory, sift registers,
// ordering register and result register. Depends on hpq_pkg.
`default_nettype none

module hpq_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire hpq_pkg::cmd_t                cmd,
  output hpq_pkg::sts_t                     sts,
  input  wire logic                         in_mode,
  input  wire hpq_pkg::data_t               in_value,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_min_order,
  output hpq_pkg::data_t                    out_root_value,
  output logic [hpq_pkg::STAT_W-1:0]        out_status,
  output logic [hpq_pkg::FILL_W-1:0]        out_fill_count
);

  localparam int AW = hpq_pkg::ADDR_W;
  localparam int CW = hpq_pkg::CNT_W;
  localparam int KW = hpq_pkg::CHILD_W;

  // Element store: one write port, two registered read ports.
  hpq_pkg::data_t mem [hpq_pkg::DEPTH];
  hpq_pkg::data_t rd_a_r, rd_b_r;

  logic                       min_order_r;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic                       mode_r;
  hpq_pkg::data_t             cur_r, cur_nxt;
  hpq_pkg::data_t             root_r, root_nxt;
  logic [hpq_pkg::STAT_W-1:0] status_r, status_nxt;

  hpq_pkg::data_t             out_root_r;
  logic [hpq_pkg::STAT_W-1:0] out_status_r;
  logic [hpq_pkg::FILL_W-1:0] out_fill_r;

  logic [AW-1:0] pos_m1;
  logic [AW-1:0] parent;
  logic [KW-1:0] left_idx, right_idx, cnt_ext;
  logic [CW-1:0] cnt_m1;
  logic          right_ok, pick_right;
  logic [AW-1:0] pick_idx;
  hpq_pkg::data_t pick_val;

  logic           we;
  logic [AW-1:0]  wa;
  hpq_pkg::data_t wd;
  logic           re_a, re_b;
  logic [AW-1:0]  ra_a, ra_b;

  assign pos_m1    = pos_r - AW'(1);
  assign parent    = {1'b0, pos_m1[AW-1:1]};
  assign left_idx  = KW'({pos_r, 1'b1});
  assign right_idx = left_idx + KW'(1);
  assign cnt_ext   = KW'(cnt_r);
  assign cnt_m1    = cnt_r - CW'(1);
  assign right_ok  = (right_idx < cnt_ext);

  // Equal children send the sift to the right child.
  assign pick_right = right_ok && !hpq_pkg::beats(rd_a_r, rd_b_r, min_order_r);
  assign pick_val   = pick_right ? rd_b_r : rd_a_r;
  assign pick_idx   = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

  always_comb begin
    sts.is_remove  = (mode_r == hpq_pkg::MODE_REMOVE);
    sts.full       = (cnt_r == CW'(hpq_pkg::DEPTH));
    sts.empty      = (cnt_r == '0);
    sts.pos_zero   = (pos_r == '0);
    sts.dn_leaf    = (left_idx >= cnt_ext);
    sts.up_move_ok = hpq_pkg::beats(cur_r, rd_a_r, min_order_r);
    sts.dn_move_ok = hpq_pkg::beats(pick_val, cur_r, min_order_r);
  end

  // Memory port control.
  always_comb begin
    we = cmd.write_cur | cmd.up_move | cmd.dn_move;
    wa = pos_r;
    if (cmd.write_cur) begin
      wd = cur_r;
    end else if (cmd.up_move) begin
      wd = rd_a_r;
    end else begin
      wd = pick_val;
    end
    re_a = cmd.rm_start | cmd.rd_parent | cmd.rd_children;
    re_b = cmd.rm_start | cmd.rd_children;
    if (cmd.rm_start) begin
      ra_a = '0;
    end else if (cmd.rd_parent) begin
      ra_a = parent;
    end else begin
      ra_a = left_idx[AW-1:0];
    end
    ra_b = cmd.rm_start ? cnt_m1[AW-1:0] : right_idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re_a) begin
      rd_a_r <= mem[ra_a];
    end
    if (re_b) begin
      rd_b_r <= mem[ra_b];
    end
  end

  // Working registers of the item in flight.
  always_comb begin
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    cur_nxt    = cur_r;
    root_nxt   = root_r;
    status_nxt = status_r;
    if (cmd.accept) begin
      cur_nxt = in_value;
    end
    if (cmd.set_full) begin
      root_nxt   = '0;
      status_nxt = hpq_pkg::STAT_FULL;
    end
    if (cmd.set_empty) begin
      root_nxt   = '0;
      status_nxt = hpq_pkg::STAT_EMPTY;
    end
    if (cmd.ins_start) begin
      root_nxt   = '0;
      status_nxt = hpq_pkg::STAT_DONE;
      pos_nxt    = cnt_r[AW-1:0];
      cnt_nxt    = cnt_r + CW'(1);
    end
    if (cmd.rm_start) begin
      status_nxt = hpq_pkg::STAT_DONE;
      pos_nxt    = '0;
      cnt_nxt    = cnt_m1;
    end
    if (cmd.rm_load) begin
      root_nxt = rd_a_r;
      cur_nxt  = rd_b_r;
    end
    if (cmd.up_move) begin
      pos_nxt = parent;
    end
    if (cmd.dn_move) begin
      pos_nxt = pick_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      min_order_r <= 1'b1;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        min_order_r <= cfg_min_order;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    root_r   <= root_nxt;
    status_r <= status_nxt;
    if (cmd.accept) begin
      mode_r <= in_mode;
    end
    if (cmd.out_load) begin
      out_root_r   <= root_r;
      out_status_r <= status_r;
      out_fill_r   <= hpq_pkg::FILL_W'(cnt_r);
    end
  end

  assign out_root_value = out_root_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

endmodule

`default_nettype wire

### src/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: controller plus datapath.
// Depends on hpq_pkg, the channel interfaces in hpq_ifs, hpq_ctrl and hpq_dp.
//
//   Channel   Direction  Payload                              Handshake
//   in_ch     sink       mode (1), value (32, signed)         valid / ready
//   out_ch    source     root_value (32), status (2),         valid / ready
//                        fill_count (6)
//   cfg_ch    sink       min_order (1)                        valid / ready, always ready
//
// One item is worked on at a time. An insert passes from acceptance through the decide
// state and then, for each level the value climbs, a read of the parent and a compare;
// a remove loads the root and the last element and then, for each level the moved
// element sinks, a read of both children and a compare. A remove that empties the heap
// goes straight from the load to the result. The slowest item is an insert into 31
// elements that climbs five levels. The bound is the element memory: each level reads
// through its registered port in one state and compares and writes in a second state.
// Rejected inserts and removes on an empty heap go from the decide state to the result.
// The controller returns to idle after it loads the result register, and only then
// accepts the next item, so it takes no new item before the last one is through.
// Reset (rst_n low, synchronous) empties the heap and selects min ordering;
// the memory itself is not cleared. A stalled result stays in its output
// register while the next item is accepted and worked on.
`default_nettype none

module binary_heap_priority_queue (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hpq_in_if.sink      in_ch,
  hpq_out_if.source   out_ch,
  hpq_cfg_if.sink     cfg_ch
);

  hpq_pkg::cmd_t cmd;
  hpq_pkg::sts_t sts;

  // The ordering register can be written in any cycle; the user must write it only
  // while the queue is idle, as the block itself does not enforce this.
  assign cfg_ch.ready = 1'b1;

  hpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hpq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_ch.mode),
    .in_value       (in_ch.value),
    .cfg_we         (cfg_ch.valid),
    .cfg_min_order  (cfg_ch.min_order),
    .out_root_value (out_ch.root_value),
    .out_status     (out_ch.status),
    .out_fill_count (out_ch.fill_count)
  );

endmodule

`default_nettype wire

### sim/binary_heap_priority_queue_tb.sv
// Self-checking testbench for binary_heap_priority_queue: random insert and poll traffic
// under both orderings, checked against an in-bench heap predictor. Depends on hpq_pkg,
// the channel interfaces in hpq_ifs and the block's top level.
`default_nettype none

module binary_heap_priority_queue_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam hpq_pkg::data_t VAL_MAX = 32'sh7FFF_FFFF;
  localparam hpq_pkg::data_t VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic           mode;
    hpq_pkg::data_t value;
  } heap_op_t;

  typedef struct {
    hpq_pkg::data_t               root_value;
    logic [hpq_pkg::STAT_W-1:0]   status;
    logic [hpq_pkg::FILL_W-1:0]   fill_count;
  } heap_result_t;

  typedef enum int {MIX_WIDE, MIX_DUPS, FILL_DRAIN} traffic_t;

  logic clk = 1'b0;
  logic rst_n;

  hpq_in_if  in_if ();
  hpq_out_if out_if ();
  hpq_cfg_if cfg_if ();

  binary_heap_priority_queue u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Operations waiting for the driver, and results owed by the block in order.
  heap_op_t     queued_ops[$];
  heap_result_t due_results[$];

  // Shadow copy of the heap; entries at or above shadow_count are never read.
  hpq_pkg::data_t shadow_heap[hpq_pkg::DEPTH];
  int             shadow_count;
  logic           shadow_min_order;

  int gen_count;
  int fail_count;
  int n_insert, n_remove, n_full, n_empty, n_orders, n_checked;
  int burst_left, gap_left;
  int stall_age;
  logic [15:0] stall_pat;
  int idle_cycles;
  heap_op_t drive_op;
  heap_result_t seen;

  // Strict ordering test: a belongs above b under the current setting.
  function automatic logic outranks(hpq_pkg::data_t a, hpq_pkg::data_t b);
    return shadow_min_order ? (a < b) : (a > b);
  endfunction

  function automatic void swap_slots(int i, int j);
    hpq_pkg::data_t t;
    t = shadow_heap[i];
    shadow_heap[i] = shadow_heap[j];
    shadow_heap[j] = t;
  endfunction

  // Applies one operation to the shadow heap and returns the result it must produce.
  function automatic heap_result_t heap_apply(logic op_mode, hpq_pkg::data_t val);
    heap_result_t r;
    int pos, up_idx, left, right, pick;
    r.root_value = '0;
    r.status = hpq_pkg::STAT_DONE;
    if (op_mode == hpq_pkg::MODE_INSERT) begin
      if (shadow_count >= hpq_pkg::DEPTH) begin
        r.status = hpq_pkg::STAT_FULL;
      end else begin
        pos = shadow_count;
        shadow_heap[pos] = val;
        shadow_count++;
        while (pos > 0) begin
          up_idx = (pos - 1) / 2;
          if (!outranks(shadow_heap[pos], shadow_heap[up_idx])) break;
          swap_slots(pos, up_idx);
          pos = up_idx;
        end
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = hpq_pkg::STAT_EMPTY;
      end else begin
        r.root_value = shadow_heap[0];
        shadow_heap[0] = shadow_heap[shadow_count - 1];
        shadow_count--;
        pos = 0;
        while (1) begin
          left = 2 * pos + 1;
          right = left + 1;
          if (left >= shadow_count) break;
          // Equal children lose the left-side test, so the sift goes right.
          if (right >= shadow_count || outranks(shadow_heap[left], shadow_heap[right])) begin
            pick = left;
          end else begin
            pick = right;
          end
          if (!outranks(shadow_heap[pick], shadow_heap[pos])) break;
          swap_slots(pick, pos);
          pos = pick;
        end
      end
    end
    r.fill_count = shadow_count[hpq_pkg::FILL_W-1:0];
    return r;
  endfunction

  // Driver: bursts of back-to-back items separated by random gaps. Prediction happens
  // at the edge where an item is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.mode  <= hpq_pkg::MODE_INSERT;
      in_if.value <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        due_results.push_back(heap_apply(in_if.mode, in_if.value));
        if (in_if.mode == hpq_pkg::MODE_INSERT) n_insert++; else n_remove++;
        if (due_results[$].status == hpq_pkg::STAT_FULL) n_full++;
        if (due_results[$].status == hpq_pkg::STAT_EMPTY) n_empty++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (queued_ops.size() > 0) begin
          drive_op = queued_ops.pop_front();
          in_if.valid <= 1'b1;
          in_if.mode  <= drive_op.mode;
          in_if.value <= drive_op.value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: the receiver stalls on a rotating pattern that is redrawn now and then.
  // The pattern always has at least one set bit, so every stall comes to an end.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_pat = 16'hFFFF;
      stall_age = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_checked++;
        if (due_results.size() == 0) begin
          $error("result with no item outstanding: root_value %0d status %0d fill_count %0d",
                 out_if.root_value, out_if.status, out_if.fill_count);
          fail_count++;
        end else begin
          seen = due_results.pop_front();
          if (out_if.root_value !== seen.root_value) begin
            $error("root_value mismatch: expected %0d, got %0d",
                   seen.root_value, out_if.root_value);
            fail_count++;
          end
          if (out_if.status !== seen.status) begin
            $error("status mismatch: expected %0d, got %0d", seen.status, out_if.status);
            fail_count++;
          end
          if (out_if.fill_count !== seen.fill_count) begin
            $error("fill_count mismatch: expected %0d, got %0d",
                   seen.fill_count, out_if.fill_count);
            fail_count++;
          end
        end
      end
      if (stall_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = 16'hFFFF;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom & $urandom);
          default: stall_pat = 16'($urandom | $urandom);
        endcase
        stall_pat[0] = 1'b1;
        stall_age = $urandom_range(20, 80);
      end else begin
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        stall_age--;
      end
      out_if.ready <= stall_pat[0];
    end
  end

  // Watchdog: any accepted item on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without progress", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_op(logic op_mode, hpq_pkg::data_t val);
    heap_op_t op;
    op.mode = op_mode;
    op.value = val;
    queued_ops.push_back(op);
    if (op_mode == hpq_pkg::MODE_INSERT) begin
      if (gen_count < hpq_pkg::DEPTH) gen_count++;
    end else if (gen_count > 0) begin
      gen_count--;
    end
  endtask

  // Returns once the driver is empty and every owed result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (queued_ops.size() != 0 || due_results.size() != 0 || in_if.valid);
  endtask

  task automatic set_order(logic order);
    wait_drained();
    @(posedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.min_order <= order;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    shadow_min_order = order;
    n_orders++;
    @(negedge clk);
  endtask

  function automatic hpq_pkg::data_t pick_value(traffic_t style);
    hpq_pkg::data_t v;
    if (style == MIX_DUPS) begin
      v = hpq_pkg::data_t'($urandom_range(0, 6)) - 3;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = $urandom;
        4, 5:       v = hpq_pkg::data_t'($urandom_range(0, 8)) - 4;
        6:          v = VAL_MAX - hpq_pkg::data_t'($urandom_range(0, 2));
        7:          v = VAL_MIN + hpq_pkg::data_t'($urandom_range(0, 2));
        default:    v = -hpq_pkg::data_t'($urandom_range(1, 1000));
      endcase
    end
    return v;
  endfunction

  // Mixed traffic keeps the heap partly filled; a fill-and-drain run pushes it past
  // full and then polls it past empty.
  task automatic run_traffic(traffic_t style, int n_ops);
    int k;
    int ins_pct;
    if (style == FILL_DRAIN) begin
      while (gen_count < hpq_pkg::DEPTH) queue_op(hpq_pkg::MODE_INSERT, pick_value(MIX_WIDE));
      for (k = 0; k < 3; k++) queue_op(hpq_pkg::MODE_INSERT, pick_value(MIX_WIDE));
      while (gen_count > 0) queue_op(hpq_pkg::MODE_REMOVE, pick_value(MIX_WIDE));
      for (k = 0; k < 2; k++) queue_op(hpq_pkg::MODE_REMOVE, pick_value(MIX_WIDE));
    end else begin
      for (k = 0; k < n_ops; k++) begin
        ins_pct = (gen_count < 4) ? 75 : 55;
        if ($urandom_range(1, 100) <= ins_pct) begin
          queue_op(hpq_pkg::MODE_INSERT, pick_value(style));
        end else begin
          queue_op(hpq_pkg::MODE_REMOVE, pick_value(style));
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.min_order = 1'b1;
    shadow_count = 0;
    shadow_min_order = 1'b1;
    gen_count = 0;
    fail_count = 0;
    idle_cycles = 0;
    n_insert = 0; n_remove = 0; n_full = 0; n_empty = 0; n_orders = 0; n_checked = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset ordering (min at the root).
    // Poll on an empty heap.
    queue_op(hpq_pkg::MODE_REMOVE, '0);
    // On the first of the polls below, 9 moves to the root over two equal children of 3.
    queue_op(hpq_pkg::MODE_INSERT, 1);
    queue_op(hpq_pkg::MODE_INSERT, 3);
    queue_op(hpq_pkg::MODE_INSERT, 3);
    queue_op(hpq_pkg::MODE_INSERT, 9);
    repeat (4) queue_op(hpq_pkg::MODE_REMOVE, VAL_MAX);
    // A value equal to its parent must not climb.
    queue_op(hpq_pkg::MODE_INSERT, 4);
    queue_op(hpq_pkg::MODE_INSERT, 4);
    repeat (2) queue_op(hpq_pkg::MODE_REMOVE, VAL_MIN);
    // Extremes of the value field.
    queue_op(hpq_pkg::MODE_INSERT, VAL_MAX);
    queue_op(hpq_pkg::MODE_INSERT, VAL_MIN);
    queue_op(hpq_pkg::MODE_INSERT, 0);
    queue_op(hpq_pkg::MODE_INSERT, -1);
    repeat (4) queue_op(hpq_pkg::MODE_REMOVE, -1);

    // Random part. Ordering changes fall between phases, some while elements are still
    // stored, so later sifts can run on an array built under the other ordering.
    set_order(1'b0);
    run_traffic(FILL_DRAIN, 0);
    set_order(1'b1);
    run_traffic(MIX_WIDE, 70);
    set_order(1'b0);
    run_traffic(MIX_DUPS, 70);
    set_order(1'b1);
    run_traffic(FILL_DRAIN, 0);
    set_order(1'b0);
    run_traffic(MIX_WIDE, 70);
    set_order(1'b1);
    run_traffic(MIX_DUPS, 50);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d inserts (%0d dropped on full) and %0d polls (%0d on empty),",
             n_insert, n_full, n_remove, n_empty);
    $display("%0d results checked across %0d ordering writes", n_checked, n_orders);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
